/* sv/drp_pkg.sv */
// ----------------------------------------------------------------------------
// drp_pkg
// Shared types and constants of the decimal integer row parser: the token
// phase, the error codes, the parse state and the result beat.
// ----------------------------------------------------------------------------
package drp_pkg;

  // Longest token, minus included.
  localparam int unsigned MAX_TOKEN_CHARS = 20;

  localparam int unsigned CHAR_CNT_W = 5;
  localparam int unsigned COL_CNT_W  = 16;
  localparam int unsigned VALUE_W    = 64;

  // Widened magnitude used for the multiply-by-ten check.
  localparam int unsigned PROD_W = VALUE_W + 4;
  localparam logic [PROD_W-1:0] LIMIT_MAG = {4'b0000, 1'b1, {(VALUE_W-1){1'b0}}};

  localparam logic [COL_CNT_W-1:0] EXPECTED_COLUMNS_RESET = 16'd1;

  // Character codes.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Configuration register index.
  localparam logic REG_EXPECTED_COLUMNS = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_MINUS  = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ERR_BAD_CHAR    = 3'd0,
    ERR_LONE_MINUS  = 3'd1,
    ERR_INNER_MINUS = 3'd2,
    ERR_TOO_LONG    = 3'd3,
    ERR_RANGE       = 3'd4,
    ERR_TOO_MANY    = 3'd5,
    ERR_TOO_FEW     = 3'd6
  } err_t;

  typedef struct packed {
    phase_t                phase;
    logic                  neg;
    logic [VALUE_W-1:0]    mag;
    logic                  mag_ovf;
    logic [CHAR_CNT_W-1:0] char_cnt;
    logic [COL_CNT_W-1:0]  col_cnt;
    logic                  halted;
  } parse_state_t;

  typedef struct packed {
    logic               value_valid;
    logic [VALUE_W-1:0] value;
    logic               line_done;
    logic               input_done;
    logic               error_flag;
    err_t               error_code;
  } result_t;

endpackage

/* sv/drp_step.sv */
// ----------------------------------------------------------------------------
// drp_step
// Combinational parse step: from the current state and one input beat it
// forms the next state and, where one is due, a result beat.
// ----------------------------------------------------------------------------
module drp_step #(
  parameter int unsigned MAX_TOKEN_CHARS = drp_pkg::MAX_TOKEN_CHARS
) (
  input  drp_pkg::parse_state_t           st,
  input  logic [7:0]                      char_code,
  input  logic                            end_of_stream,
  input  logic [drp_pkg::COL_CNT_W-1:0]   expected_columns,
  output drp_pkg::parse_state_t           st_nxt,
  output logic                            emit,
  output drp_pkg::result_t                res
);

  logic                          is_nl;
  logic                          is_sep;
  logic                          is_digit;
  logic                          is_minus;
  logic [3:0]                    digit;
  logic [drp_pkg::PROD_W-1:0]    prod;
  logic                          prod_ovf;

  // Character classes; the low nibble of a digit code is its value.
  assign is_nl    = (char_code == drp_pkg::CH_CR) || (char_code == drp_pkg::CH_LF);
  assign is_sep   = (char_code == drp_pkg::CH_SPACE) || (char_code == drp_pkg::CH_TAB);
  assign is_digit = char_code inside {[drp_pkg::CH_ZERO:drp_pkg::CH_NINE]};
  assign is_minus = (char_code == drp_pkg::CH_MINUS);
  assign digit    = char_code[3:0];

  // Multiply by ten as two shifts and an add; overflow when past 2^63.
  assign prod = {1'b0, st.mag, 3'b000} + {3'b000, st.mag, 1'b0}
              + {{(drp_pkg::PROD_W-4){1'b0}}, digit};
  assign prod_ovf = st.mag_ovf || (prod > drp_pkg::LIMIT_MAG);

  always_comb begin
    logic                         boundary;
    logic                         add;
    logic                         fail;
    drp_pkg::err_t                fail_code;
    logic                         have_val;
    logic [drp_pkg::VALUE_W-1:0]  val;
    logic [drp_pkg::COL_CNT_W-1:0] cc;

    st_nxt    = st;
    emit      = 1'b0;
    res       = '0;
    boundary  = 1'b0;
    add       = 1'b0;
    fail      = 1'b0;
    fail_code = drp_pkg::ERR_BAD_CHAR;
    have_val  = 1'b0;
    val       = '0;
    cc        = st.col_cnt;

    // Character handling inside or outside a token.
    if (!st.halted) begin
      if (!end_of_stream && st.phase == drp_pkg::PH_IDLE) begin
        if (is_sep) begin
          // Leading separators are skipped.
        end else if (is_nl) begin
          boundary = 1'b1;
        end else if (is_digit) begin
          st_nxt.phase = drp_pkg::PH_DIGITS;
          add          = 1'b1;
        end else if (is_minus) begin
          st_nxt.phase    = drp_pkg::PH_MINUS;
          st_nxt.neg      = 1'b1;
          st_nxt.char_cnt = drp_pkg::CHAR_CNT_W'(1);
        end else begin
          fail      = 1'b1;
          fail_code = drp_pkg::ERR_BAD_CHAR;
        end
      end else if (!end_of_stream && !is_sep && !is_nl) begin
        if (is_minus) begin
          fail      = 1'b1;
          fail_code = drp_pkg::ERR_INNER_MINUS;
        end else if (!is_digit) begin
          fail      = 1'b1;
          fail_code = drp_pkg::ERR_BAD_CHAR;
        end else if (st.char_cnt >= drp_pkg::CHAR_CNT_W'(MAX_TOKEN_CHARS)) begin
          fail      = 1'b1;
          fail_code = drp_pkg::ERR_TOO_LONG;
        end else begin
          st_nxt.phase = drp_pkg::PH_DIGITS;
          add          = 1'b1;
        end
      end else begin
        boundary = 1'b1;
      end
    end

    // Digit accumulation with a sticky overflow bit.
    if (add) begin
      if (prod_ovf) begin
        st_nxt.mag_ovf = 1'b1;
      end else begin
        st_nxt.mag = prod[drp_pkg::VALUE_W-1:0];
      end
      st_nxt.char_cnt = st.char_cnt + drp_pkg::CHAR_CNT_W'(1);
    end

    // Token boundary: finish the open value, then close the line or input.
    if (boundary) begin
      if (st.phase == drp_pkg::PH_MINUS) begin
        fail      = 1'b1;
        fail_code = drp_pkg::ERR_LONE_MINUS;
      end else if (st.phase == drp_pkg::PH_DIGITS) begin
        if (st.mag_ovf || (!st.neg && st.mag[drp_pkg::VALUE_W-1])) begin
          fail      = 1'b1;
          fail_code = drp_pkg::ERR_RANGE;
        end else begin
          val             = st.neg ? (~st.mag + drp_pkg::VALUE_W'(1)) : st.mag;
          have_val        = 1'b1;
          st_nxt.phase    = drp_pkg::PH_IDLE;
          st_nxt.neg      = 1'b0;
          st_nxt.mag      = '0;
          st_nxt.mag_ovf  = 1'b0;
          st_nxt.char_cnt = '0;
          if (cc >= expected_columns) begin
            fail      = 1'b1;
            fail_code = drp_pkg::ERR_TOO_MANY;
          end else begin
            cc = cc + drp_pkg::COL_CNT_W'(1);
          end
        end
      end

      st_nxt.col_cnt = cc;

      if (!fail) begin
        if (end_of_stream) begin
          if (cc != expected_columns) begin
            fail      = 1'b1;
            fail_code = drp_pkg::ERR_TOO_FEW;
          end else begin
            st_nxt.halted   = 1'b1;
            emit            = 1'b1;
            res.value_valid = have_val;
            res.value       = val;
            res.input_done  = 1'b1;
          end
        end else if (is_nl) begin
          if (cc == '0) begin
            // A line holding no value is skipped.
          end else if (cc != expected_columns) begin
            fail      = 1'b1;
            fail_code = drp_pkg::ERR_TOO_FEW;
          end else begin
            st_nxt.col_cnt  = '0;
            emit            = 1'b1;
            res.value_valid = have_val;
            res.value       = val;
            res.line_done   = 1'b1;
          end
        end else if (have_val) begin
          emit            = 1'b1;
          res.value_valid = 1'b1;
          res.value       = val;
        end
      end
    end

    // An error replaces any other result and halts the parser.
    if (fail) begin
      st_nxt.halted  = 1'b1;
      emit           = 1'b1;
      res            = '0;
      res.error_flag = 1'b1;
      res.error_code = fail_code;
    end
  end

endmodule

/* sv/drp_out_buf.sv */
// ----------------------------------------------------------------------------
// drp_out_buf
// Two-entry result buffer: an output register and a skid register, so the
// parser keeps taking beats while a result waits downstream.
// ----------------------------------------------------------------------------
module drp_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  drp_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output drp_pkg::result_t  out_data
);

  logic             v0_r, v0_nxt;
  logic             v1_r, v1_nxt;
  drp_pkg::result_t d0_r, d0_nxt;
  drp_pkg::result_t d1_r, d1_nxt;
  logic             pop;

  assign pop = v0_r && !out_stall;

  // Slot steering: the skid slot moves forward when the head beat leaves.
  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    d0_nxt = d0_r;
    d1_nxt = d1_r;
    if (pop) begin
      if (v1_r) begin
        d0_nxt = d1_r;
        v1_nxt = push;
        d1_nxt = push_data;
      end else begin
        v0_nxt = push;
        d0_nxt = push_data;
      end
    end else if (push) begin
      if (!v0_r) begin
        v0_nxt = 1'b1;
        d0_nxt = push_data;
      end else begin
        v1_nxt = 1'b1;
        d1_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

  assign full      = v1_r;
  assign out_valid = v0_r;
  assign out_data  = d0_r;

endmodule

/* sv/decimal_integer_row_parser_core.sv */
// ----------------------------------------------------------------------------
// decimal_integer_row_parser_core
// Turns a stream of text characters into signed 64-bit integers and checks
// that every data line holds the configured number of values.
// ----------------------------------------------------------------------------
// The parser takes one character, or an end-of-input mark, per clock cycle
// while not stalled: each accepted beat is handled by the parse step, which
// updates the token state and the column count and, when a value finishes, a
// line closes, input ends or an error is found, places one result beat in a
// two-entry output buffer. A result appears on the output the cycle after
// its input beat is accepted when no older result is still waiting there.
// in_stall rises only while both buffer entries hold results that the
// downstream side has not taken. After an error or an accepted end of input
// the parser ignores all further beats until reset. The expected_columns
// register lies at byte address 0; a write takes effect at once, leaves the
// parse state alone, and should be made only while no input beat is offered.
module decimal_integer_row_parser_core #(
  parameter int unsigned MAX_TOKEN_CHARS = drp_pkg::MAX_TOKEN_CHARS
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_end_of_stream,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_value_valid,
  output logic signed [63:0] out_value,
  output logic               out_line_done,
  output logic               out_input_done,
  output logic               out_error_flag,
  output logic [2:0]         out_error_code,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  drp_pkg::parse_state_t             st_r, st_nxt;
  logic [drp_pkg::COL_CNT_W-1:0]     expected_r;
  logic                              in_fire;
  logic                              emit;
  logic                              buf_full;
  logic                              cfg_wr;
  drp_pkg::result_t                  step_res;
  drp_pkg::result_t                  out_res;

  // Configuration register write and read-back.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[2] == drp_pkg::REG_EXPECTED_COLUMNS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= drp_pkg::EXPECTED_COLUMNS_RESET;
    end else if (cfg_wr) begin
      expected_r <= pwdata[drp_pkg::COL_CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == drp_pkg::REG_EXPECTED_COLUMNS) begin
      prdata = {{(32-drp_pkg::COL_CNT_W){1'b0}}, expected_r};
    end
  end

  // Input beat handshake.
  assign in_stall = buf_full;
  assign in_fire  = in_valid && !in_stall;

  // Parse step between the state register and the result buffer.
  drp_step #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
  ) u_step (
    .st               (st_r),
    .char_code        (in_char_code),
    .end_of_stream    (in_end_of_stream),
    .expected_columns (expected_r),
    .st_nxt           (st_nxt),
    .emit             (emit),
    .res              (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Result buffer.
  drp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && emit),
    .push_data (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_value_valid = out_res.value_valid;
  assign out_value       = out_res.value;
  assign out_line_done   = out_res.line_done;
  assign out_input_done  = out_res.input_done;
  assign out_error_flag  = out_res.error_flag;
  assign out_error_code  = out_res.error_code;

endmodule

/* dv/decimal_integer_row_parser_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_integer_row_parser_core_tb
// Self-checking bench for the row parser. Text is streamed in one character
// beat at a time and every result beat is checked field by field against a
// cycle-free parser kept in step with the accepted input beats. Rows use
// several column settings, the receiver stalls in changing patterns and once
// holds off long enough to fill the block. The run ends on a randomly chosen
// clean end or error, followed by beats that the halted block must ignore.
// ----------------------------------------------------------------------------
module decimal_integer_row_parser_core_tb;

  localparam logic [63:0] MAG_CEILING     = 64'h8000_0000_0000_0000;
  localparam int          SETTLE_CYCLES   = 4;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  typedef logic [7:0] char_q_t [$];

  typedef enum int {
    END_CLEAN_OPEN,
    END_CLEAN_EMPTY,
    END_BAD_CHAR,
    END_LONE_MINUS,
    END_INNER_MINUS,
    END_TOO_LONG,
    END_RANGE,
    END_TOO_MANY,
    END_TOO_FEW
  } ending_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_char_code;
  logic               in_end_of_stream;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_value_valid;
  logic signed [63:0] out_value;
  logic               out_line_done;
  logic               out_input_done;
  logic               out_error_flag;
  logic [2:0]         out_error_code;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Parser state as the block should hold it.
  drp_pkg::phase_t tok_phase;
  logic            tok_neg;
  logic [63:0]     tok_mag;
  logic            tok_ovf;
  logic [4:0]      tok_len;
  logic [16:0]     cols_seen;
  logic            parser_halted;
  logic [15:0]     cols_cfg;

  drp_pkg::result_t pending_results [$];
  bit          failed = 1'b0;
  int          beats_sent = 0;
  int          burst_left = 0;
  int          gap_max = 6;
  int          hold_requests = 0;
  int          holds_started = 0;
  int          hold_left = 0;
  logic [31:0] stall_tick = '0;
  logic [1:0]  stall_mode = 2'd0;
  int unsigned cycle_count = 0;

  decimal_integer_row_parser_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value_valid  (out_value_valid),
    .out_value        (out_value),
    .out_line_done    (out_line_done),
    .out_input_done   (out_input_done),
    .out_error_flag   (out_error_flag),
    .out_error_code   (out_error_code),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser prediction
  // ---------------------------------------------------------------------------

  function automatic void drop_token();
    tok_phase = drp_pkg::PH_IDLE;
    tok_neg   = 1'b0;
    tok_mag   = '0;
    tok_ovf   = 1'b0;
    tok_len   = '0;
  endfunction

  // The magnitude can reach 2^63 at most; anything past that sets the
  // overflow bit instead.
  function automatic void accumulate_digit(input logic [63:0] digit);
    if (tok_ovf || tok_mag > (MAG_CEILING - digit) / 64'd10) begin
      tok_ovf = 1'b1;
    end else begin
      tok_mag = tok_mag * 64'd10 + digit;
    end
    tok_len = tok_len + 5'd1;
  endfunction

  function automatic drp_pkg::result_t halt_on_error(input drp_pkg::err_t code);
    drp_pkg::result_t res;
    res            = '0;
    res.error_flag = 1'b1;
    res.error_code = code;
    parser_halted  = 1'b1;
    return res;
  endfunction

  // Advances the parser by one accepted beat; returns 1 when a result beat
  // is due and places it in res.
  function automatic bit parse_beat(input logic [7:0] ch, input logic eos,
                                    output drp_pkg::result_t res);
    logic        is_nl;
    logic        is_sep;
    logic        is_digit;
    logic        got_val;
    logic [63:0] val;
    res      = '0;
    got_val  = 1'b0;
    val      = '0;
    is_nl    = (ch == drp_pkg::CH_CR) || (ch == drp_pkg::CH_LF);
    is_sep   = (ch == drp_pkg::CH_SPACE) || (ch == drp_pkg::CH_TAB);
    is_digit = (ch >= drp_pkg::CH_ZERO) && (ch <= drp_pkg::CH_NINE);
    if (parser_halted) return 1'b0;

    // Token characters.
    if (!eos && !is_sep && !is_nl) begin
      if (tok_phase == drp_pkg::PH_IDLE) begin
        if (is_digit) begin
          tok_phase = drp_pkg::PH_DIGITS;
          accumulate_digit(64'(ch - drp_pkg::CH_ZERO));
          return 1'b0;
        end
        if (ch == drp_pkg::CH_MINUS) begin
          tok_phase = drp_pkg::PH_MINUS;
          tok_neg   = 1'b1;
          tok_len   = 5'd1;
          return 1'b0;
        end
        res = halt_on_error(drp_pkg::ERR_BAD_CHAR);
        return 1'b1;
      end
      if (ch == drp_pkg::CH_MINUS) begin
        res = halt_on_error(drp_pkg::ERR_INNER_MINUS);
        return 1'b1;
      end
      if (!is_digit) begin
        res = halt_on_error(drp_pkg::ERR_BAD_CHAR);
        return 1'b1;
      end
      if (tok_len >= drp_pkg::MAX_TOKEN_CHARS) begin
        res = halt_on_error(drp_pkg::ERR_TOO_LONG);
        return 1'b1;
      end
      tok_phase = drp_pkg::PH_DIGITS;
      accumulate_digit(64'(ch - drp_pkg::CH_ZERO));
      return 1'b0;
    end
    if (!eos && is_sep && tok_phase == drp_pkg::PH_IDLE) return 1'b0;

    // Token boundary: separator, line end or end of input.
    if (tok_phase == drp_pkg::PH_MINUS) begin
      res = halt_on_error(drp_pkg::ERR_LONE_MINUS);
      return 1'b1;
    end
    if (tok_phase == drp_pkg::PH_DIGITS) begin
      if (tok_ovf || (!tok_neg && tok_mag > MAG_CEILING - 64'd1)) begin
        res = halt_on_error(drp_pkg::ERR_RANGE);
        return 1'b1;
      end
      val     = tok_neg ? 64'd0 - tok_mag : tok_mag;
      got_val = 1'b1;
      drop_token();
      if (cols_seen >= cols_cfg) begin
        res = halt_on_error(drp_pkg::ERR_TOO_MANY);
        return 1'b1;
      end
      cols_seen = cols_seen + 17'd1;
    end

    if (eos) begin
      if (cols_seen != cols_cfg) begin
        res = halt_on_error(drp_pkg::ERR_TOO_FEW);
        return 1'b1;
      end
      parser_halted    = 1'b1;
      res.value_valid  = got_val;
      res.value        = val;
      res.input_done   = 1'b1;
      return 1'b1;
    end

    if (is_nl) begin
      if (cols_seen == 0) return 1'b0;
      if (cols_seen != cols_cfg) begin
        res = halt_on_error(drp_pkg::ERR_TOO_FEW);
        return 1'b1;
      end
      cols_seen       = '0;
      res.value_valid = got_val;
      res.value       = val;
      res.line_done   = 1'b1;
      return 1'b1;
    end

    if (got_val) begin
      res.value_valid = 1'b1;
      res.value       = val;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Text generation
  // ---------------------------------------------------------------------------

  // Appends a decimal integer, padded with leading zeros up to pad_to
  // characters in all, minus included.
  function automatic void add_number(ref char_q_t text, input logic neg,
                                     input logic [63:0] mag, input int pad_to);
    char_q_t     digits;
    logic [63:0] rest;
    int          zeros;
    rest = mag;
    do begin
      digits.push_front(drp_pkg::CH_ZERO + 8'(rest % 64'd10));
      rest = rest / 64'd10;
    end while (rest != 0);
    zeros = pad_to - digits.size() - int'(neg);
    if (neg) text.push_back(drp_pkg::CH_MINUS);
    for (int i = 0; i < zeros; i++) text.push_back(drp_pkg::CH_ZERO);
    foreach (digits[i]) text.push_back(digits[i]);
  endfunction

  // Mostly short values, with full-width values and both range limits mixed in.
  function automatic void add_random_number(ref char_q_t text);
    logic        neg;
    logic [63:0] mag;
    int          pad_to;
    neg = ($urandom_range(0, 2) == 0);
    case ($urandom_range(0, 5))
      0, 1: mag = 64'($urandom_range(0, 9));
      2: mag = 64'($urandom_range(0, 99999));
      3: mag = {$urandom, $urandom} >> $urandom_range(1, 63);
      4: mag = {1'b0, 31'($urandom), 32'($urandom)};
      default: mag = neg ? MAG_CEILING : MAG_CEILING - 64'd1;
    endcase
    case ($urandom_range(0, 7))
      0: pad_to = drp_pkg::MAX_TOKEN_CHARS;
      1: pad_to = $urandom_range(0, drp_pkg::MAX_TOKEN_CHARS);
      default: pad_to = 0;
    endcase
    add_number(text, neg, mag, pad_to);
  endfunction

  function automatic void add_blanks(ref char_q_t text, input int least);
    int count;
    count = $urandom_range(least, least + 2);
    repeat (count) begin
      text.push_back(($urandom_range(0, 1) == 0) ? drp_pkg::CH_SPACE : drp_pkg::CH_TAB);
    end
  endfunction

  function automatic logic [7:0] boundary_char();
    case ($urandom_range(0, 3))
      0: return drp_pkg::CH_SPACE;
      1: return drp_pkg::CH_TAB;
      2: return drp_pkg::CH_LF;
      default: return drp_pkg::CH_CR;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input and configuration drivers
  // ---------------------------------------------------------------------------

  // Offers one beat, holding it until the block takes it; bursts of beats are
  // separated by random gaps.
  task automatic send_beat(input logic [7:0] ch, input logic eos);
    drp_pkg::result_t res;
    int               gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_char_code     <= ch;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (parse_beat(ch, eos, res)) pending_results.push_back(res);
  endtask

  task automatic send_text(input char_q_t text);
    foreach (text[i]) send_beat(text[i], 1'b0);
  endtask

  // Sends one row of values; a continued row carries on a line already open.
  task automatic send_row(input int values, input bit close, input bit continued);
    char_q_t text;
    if (!continued && $urandom_range(0, 7) == 0) begin
      add_blanks(text, 0);
      text.push_back(drp_pkg::CH_LF);
    end
    add_blanks(text, continued ? 1 : 0);
    for (int i = 0; i < values; i++) begin
      if (i != 0) add_blanks(text, 1);
      add_random_number(text);
    end
    if (close) begin
      add_blanks(text, 0);
      case ($urandom_range(0, 2))
        0: text.push_back(drp_pkg::CH_LF);
        1: text.push_back(drp_pkg::CH_CR);
        default: begin
          text.push_back(drp_pkg::CH_CR);
          text.push_back(drp_pkg::CH_LF);
        end
      endcase
    end
    send_text(text);
  endtask

  // Stops offering beats and waits until every expected result has drained.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      failed = 1'b1;
    end
  endtask

  task automatic read_columns(input logic [15:0] want);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {drp_pkg::REG_EXPECTED_COLUMNS, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    compare_field("expected_columns", 64'(want), 64'(prdata[15:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_columns(input logic [15:0] cols);
    wait_until_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {drp_pkg::REG_EXPECTED_COLUMNS, 2'b00};
    pwdata  <= {16'd0, cols};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cols_cfg = cols;
    read_columns(cols);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A blank line, then the most negative value after a space and a tab,
  // closed by CR LF so that the LF lands on an empty line.
  task automatic test_directed_extremes();
    char_q_t text;
    read_columns(drp_pkg::EXPECTED_COLUMNS_RESET);
    text.push_back(drp_pkg::CH_LF);
    text.push_back(drp_pkg::CH_SPACE);
    text.push_back(drp_pkg::CH_TAB);
    add_number(text, 1'b1, MAG_CEILING, 0);
    text.push_back(drp_pkg::CH_CR);
    text.push_back(drp_pkg::CH_LF);
    send_text(text);
  endtask

  task automatic test_column_settings();
    int row_widths [6] = '{1, 3, 2, 12, 5, 1};
    int phase_start;
    foreach (row_widths[p]) begin
      write_columns(16'(row_widths[p]));
      gap_max = ($urandom_range(0, 1) == 0) ? 0 : 8;
      phase_start = beats_sent;
      while (beats_sent - phase_start < 64) send_row(row_widths[p], 1'b1, 1'b0);
    end
  endtask

  // The receiver holds off while one-value rows keep coming, so the result
  // buffer fills and the input stalls.
  task automatic test_backpressure();
    int phase_start;
    write_columns(16'd1);
    gap_max = 0;
    hold_requests++;
    phase_start = beats_sent;
    while (beats_sent - phase_start < 80) send_row(1, 1'b1, 1'b0);
    gap_max = 6;
  endtask

  // The widest column setting, then a smaller one written mid-line.
  task automatic test_wide_column_count();
    write_columns(16'hFFFF);
    send_row(4, 1'b0, 1'b0);
    write_columns(16'd6);
    send_row(2, 1'b1, 1'b1);
  endtask

  // Ends the stream with one randomly chosen clean end or error.
  task automatic test_ending();
    char_q_t    tail;
    ending_t    how;
    logic [7:0] bad;
    bit         finish_eos;
    int         cols;
    cols = $urandom_range(2, 4);
    write_columns(16'(cols));
    send_row(cols, 1'b1, 1'b0);
    how = ending_t'($urandom_range(0, 8));
    finish_eos = 1'b0;
    add_blanks(tail, 0);
    case (how)
      END_CLEAN_OPEN: begin
        send_row(cols, 1'b0, 1'b0);
        finish_eos = 1'b1;
      end
      END_CLEAN_EMPTY: begin
        write_columns(16'd0);
        finish_eos = 1'b1;
      end
      END_BAD_CHAR: begin
        if ($urandom_range(0, 1) == 0) add_random_number(tail);
        do bad = 8'($urandom_range(0, 255));
        while (bad inside {[drp_pkg::CH_ZERO:drp_pkg::CH_NINE], drp_pkg::CH_MINUS,
                           drp_pkg::CH_SPACE, drp_pkg::CH_TAB, drp_pkg::CH_LF,
                           drp_pkg::CH_CR});
        tail.push_back(bad);
      end
      END_LONE_MINUS: begin
        tail.push_back(drp_pkg::CH_MINUS);
        finish_eos = ($urandom_range(0, 3) == 0);
        if (!finish_eos) tail.push_back(boundary_char());
      end
      END_INNER_MINUS: begin
        if ($urandom_range(0, 1) == 0) tail.push_back(drp_pkg::CH_MINUS);
        else add_random_number(tail);
        tail.push_back(drp_pkg::CH_MINUS);
      end
      END_TOO_LONG: begin
        add_number(tail, $urandom_range(0, 1) == 0, 64'($urandom_range(0, 999)),
                   drp_pkg::MAX_TOKEN_CHARS);
        tail.push_back(drp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
      END_RANGE: begin
        case ($urandom_range(0, 2))
          0: add_number(tail, 1'b0, MAG_CEILING,
                        $urandom_range(0, drp_pkg::MAX_TOKEN_CHARS));
          1: add_number(tail, 1'b1, MAG_CEILING + 64'($urandom_range(1, 1000)), 0);
          default: repeat (drp_pkg::MAX_TOKEN_CHARS) tail.push_back(drp_pkg::CH_NINE);
        endcase
        finish_eos = ($urandom_range(0, 3) == 0);
        if (!finish_eos) tail.push_back(boundary_char());
      end
      END_TOO_MANY: send_row(cols + 1, 1'b1, 1'b0);
      default: begin
        finish_eos = ($urandom_range(0, 1) == 0);
        send_row(cols - 1, !finish_eos, 1'b0);
      end
    endcase
    send_text(tail);
    if (finish_eos) send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // After halting the block must ignore everything, end marks included.
  task automatic test_halted_noise();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    repeat (40) send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_result
    drp_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat arrived with none expected");
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        compare_field("value_valid", 64'(want.value_valid), 64'(out_value_valid));
        compare_field("value", want.value, out_value);
        compare_field("line_done", 64'(want.line_done), 64'(out_line_done));
        compare_field("input_done", 64'(want.input_done), 64'(out_input_done));
        compare_field("error_flag", 64'(want.error_flag), 64'(out_error_flag));
        compare_field("error_code", 64'(want.error_code), 64'(out_error_code));
      end
    end
  end

  // Receiver stall: a long hold-off on request, otherwise a pattern that
  // changes whenever the low six bits of stall_tick return to zero.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 32'd1;
    if (holds_started != hold_requests) begin
      holds_started <= hold_requests;
      hold_left     <= HOLD_OFF_CYCLES;
      out_stall     <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_tick[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_tick[2];
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("decimal_integer_row_parser_core: mismatch");
      $finish;
    end
  end

  initial begin
    in_valid         <= 1'b0;
    in_char_code     <= '0;
    in_end_of_stream <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    rst_n            <= 1'b0;
    drop_token();
    cols_seen     = '0;
    parser_halted = 1'b0;
    cols_cfg      = drp_pkg::EXPECTED_COLUMNS_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_column_settings();
    test_backpressure();
    test_wide_column_count();
    test_ending();
    test_halted_noise();

    wait_until_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("decimal_integer_row_parser_core: match");
    end else begin
      $display("decimal_integer_row_parser_core: mismatch");
    end
    $finish;
  end

endmodule
